// File: sv/mtf_pkg.sv
// Shared constants and types for the move-to-front codec.
package mtf_pkg;

    localparam int DATA_W      = 8;
    localparam int SYMBOLS_DEF = 256;

    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    typedef struct packed {
        logic              valid;
        logic              found;
        logic [DATA_W-1:0] carry;
        logic [DATA_W-1:0] sym;
        logic [DATA_W-1:0] rank;
    } t_wave;

    typedef struct packed {
        logic              mode;
        logic [DATA_W-1:0] key;
        logic              restore;
        logic [DATA_W-1:0] front_sym;
    } t_cell_ctl;

endpackage

// File: sv/move_to_front_codec_unit.sv
// Top level of the move-to-front codec: control and the chain of list cells.
//
//  Channel   Direction  Ports                         Contents
//  s_axis    in         tvalid tready tdata tlast     value, block_end
//  m_axis    out        tvalid tready tdata           code
//  cfg       in         we wdata                      mode
//
// A new word is accepted only once the previous result has moved to the output register:
// the update wave walks the chain one cell per cycle, the last cell's word is collected,
// then the result moves to the output register. An encoded symbol outside the alphabet
// skips the wave. Reset restores identity order and clears the mode; a stalled output
// word holds the next finished result in place and the input waits meanwhile.
module move_to_front_codec_unit #(
    parameter int SYMBOLS = mtf_pkg::SYMBOLS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic [mtf_pkg::DATA_W-1:0] i_s_axis_tdata,  // value [7:0]
    input  logic                      i_s_axis_tlast,
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    output logic [mtf_pkg::DATA_W-1:0] o_m_axis_tdata,  // code [7:0]
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_wdata
);
    import mtf_pkg::*;

    localparam logic [DATA_W-1:0] LAST_POS = DATA_W'(SYMBOLS - 1);
    localparam logic [DATA_W:0]   SYM_CNT  = (DATA_W + 1)'(SYMBOLS);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_HOLD = 3'b100
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic              r_mode;
    logic [DATA_W-1:0] r_key;
    logic [DATA_W-1:0] n_key;
    logic              r_last;
    logic              r_inj;
    logic [DATA_W-1:0] r_code;
    logic [DATA_W-1:0] n_code;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;

    t_wave             w_link [SYMBOLS+1];
    t_cell_ctl         w_ctl;
    logic              w_accept;
    logic              w_over;
    logic              w_skip;
    logic              w_done;
    logic              w_out_load;

    assign w_accept   = i_s_axis_tvalid && (r_state == S_IDLE);
    assign w_over     = {1'b0, i_s_axis_tdata} >= SYM_CNT;
    assign w_skip     = (r_mode == MODE_ENC) && w_over;
    assign w_done     = (r_state == S_RUN) && w_link[SYMBOLS].valid;
    assign w_out_load = (r_state == S_HOLD) && (!r_out_valid || i_m_axis_tready);

    assign w_link[0] = '{valid: r_inj, found: 1'b0, carry: '0, sym: '0, rank: '0};

    assign w_ctl.mode      = r_mode;
    assign w_ctl.key       = r_key;
    assign w_ctl.restore   = (w_accept && w_skip && i_s_axis_tlast) || (w_done && r_last);
    assign w_ctl.front_sym = w_link[SYMBOLS].sym;

    genvar g;
    generate
        for (g = 0; g < SYMBOLS; g++) begin : g_cell
            mtf_cell #(
                .INDEX (g)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl),
                .i_front_we ((g == 0) ? w_done : 1'b0),
                .i_wave     (w_link[g]),
                .o_wave     (w_link[g+1])
            );
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        n_key   = r_key;
        n_code  = r_code;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_skip) begin
                        n_code  = i_s_axis_tdata;
                        n_state = S_HOLD;
                    end else begin
                        n_key   = ((r_mode == MODE_DEC) && w_over) ? LAST_POS
                                                                   : i_s_axis_tdata;
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: begin
                if (w_done) begin
                    n_code  = (r_mode == MODE_DEC) ? w_link[SYMBOLS].sym
                                                   : w_link[SYMBOLS].rank;
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_ENC;
            r_inj       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_inj   <= w_accept && !w_skip;
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_code <= n_code;
        if (w_accept) begin
            r_last <= i_s_axis_tlast;
        end
        if (w_out_load) begin
            r_out_data <= r_code;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// File: sv/mtf_cell.sv
// One list position: holds an entry and passes the update wave to its neighbor.
module mtf_cell #(
    parameter int INDEX = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mtf_pkg::t_cell_ctl i_ctl,
    input  logic              i_front_we,
    input  mtf_pkg::t_wave    i_wave,
    output mtf_pkg::t_wave    o_wave
);
    import mtf_pkg::*;

    localparam logic [DATA_W-1:0] IDX = DATA_W'(INDEX);

    logic [DATA_W-1:0] r_entry;
    logic [DATA_W-1:0] n_entry;
    t_wave             r_wave;
    t_wave             n_wave;
    logic              w_hit;
    logic              w_live;

    assign w_live = i_wave.valid && !i_wave.found;
    assign w_hit  = w_live && ((i_ctl.mode == MODE_DEC) ? (IDX == i_ctl.key)
                                                         : (r_entry == i_ctl.key));

    always_comb begin
        n_entry = r_entry;
        n_wave  = i_wave;
        if (i_ctl.restore) begin
            n_entry = IDX;
        end else if (i_front_we) begin
            n_entry = i_ctl.front_sym;
        end else if (w_hit) begin
            n_wave.found = 1'b1;
            n_wave.sym   = r_entry;
            n_wave.rank  = IDX;
            if (INDEX != 0) begin
                n_entry = i_wave.carry;
            end
        end else if (w_live) begin
            n_wave.carry = r_entry;
            if (INDEX != 0) begin
                n_entry = i_wave.carry;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= IDX;
            r_wave  <= '0;
        end else begin
            r_entry <= n_entry;
            r_wave  <= n_wave;
        end
    end

    assign o_wave = r_wave;

endmodule

// File: tb/tb.sv
// Self-checking testbench for the move-to-front codec: stream stimulus and result check.
`timescale 1ns / 100ps

module tb;
    import mtf_pkg::*;

    localparam int SYMBOLS        = SYMBOLS_DEF;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SINK_HOLD_LEN  = 600;
    localparam int PHASE_WORDS    = 320;
    localparam int MAX_PRINTED    = 40;

    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              i_s_axis_tvalid = 1'b0;
    logic              o_s_axis_tready;
    logic [DATA_W-1:0] i_s_axis_tdata  = '0;   // value [7:0]
    logic              i_s_axis_tlast  = 1'b0; // block_end
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready = 1'b0;
    logic [DATA_W-1:0] o_m_axis_tdata;         // code [7:0]
    logic              i_cfg_we        = 1'b0;
    logic              i_cfg_wdata     = 1'b0;

    logic [DATA_W-1:0] recency [SYMBOLS];
    logic              codec_mode;
    logic [DATA_W-1:0] code_expect_q [$];
    int                err_count     = 0;
    int                stall_cycles  = 0;
    bit                idle_en       = 1'b1;
    bit                sink_hold_req = 1'b0;

    move_to_front_codec_unit #(
        .SYMBOLS(SYMBOLS)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tlast (i_s_axis_tlast),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    function automatic void restore_identity();
        int i;
        for (i = 0; i < SYMBOLS; i++) begin
            recency[i] = i[DATA_W-1:0];
        end
    endfunction

    function automatic logic [DATA_W-1:0] mtf_code(input logic [DATA_W-1:0] value,
                                                   input logic block_end);
        logic [DATA_W-1:0] code;
        logic [DATA_W-1:0] sym;
        int                pos;
        int                i;
        bit                hit;
        code = value;
        pos  = 0;
        hit  = 1'b0;
        if (codec_mode == MODE_ENC) begin
            for (i = 0; i < SYMBOLS; i++) begin
                if (!hit && recency[i] == value) begin
                    hit = 1'b1;
                    pos = i;
                end
            end
            if (hit) begin
                code = pos[DATA_W-1:0];
            end
        end else begin
            pos  = (int'(value) >= SYMBOLS) ? SYMBOLS - 1 : int'(value);
            code = recency[pos];
            hit  = 1'b1;
        end
        if (hit) begin
            sym = recency[pos];
            for (i = pos; i > 0; i--) begin
                recency[i] = recency[i-1];
            end
            recency[0] = sym;
        end
        if (block_end) begin
            restore_identity();
        end
        return code;
    endfunction

    task automatic report_error(input string msg);
        err_count++;
        if (err_count <= MAX_PRINTED) begin
            $display("tb: mismatch at %0t: %s", $realtime, msg);
        end
    endtask

    task automatic send_word(input logic [DATA_W-1:0] value, input logic block_end);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= value;
        i_s_axis_tlast  <= block_end;
        do begin
            @(posedge i_clk);
        end while (!o_s_axis_tready);
        code_expect_q.push_back(mtf_code(value, block_end));
    endtask

    task automatic wait_results_done();
        i_s_axis_tvalid <= 1'b0;
        while (code_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic mode_bit);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode_bit;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        codec_mode = mode_bit;
    endtask

    task automatic test_directed_encode();
        send_word(8'd0,   1'b0);
        send_word(8'd0,   1'b0);
        send_word(8'd255, 1'b0);
        send_word(8'd255, 1'b0);
        send_word(8'd1,   1'b0);
        send_word(8'd0,   1'b0);
        send_word(8'd128, 1'b1);
        send_word(8'd255, 1'b0);
        send_word(8'd170, 1'b0);
        send_word(8'd85,  1'b1);
        send_word(8'd85,  1'b0);
        wait_results_done();
    endtask

    task automatic test_directed_decode();
        write_mode(MODE_DEC);
        send_word(8'd0,   1'b0);
        send_word(8'd255, 1'b0);
        send_word(8'd255, 1'b0);
        send_word(8'd0,   1'b0);
        send_word(8'd1,   1'b0);
        send_word(8'd128, 1'b1);
        send_word(8'd255, 1'b0);
        send_word(8'd170, 1'b0);
        send_word(8'd85,  1'b1);
        send_word(8'd85,  1'b0);
        wait_results_done();
    endtask

    task automatic test_output_backpressure();
        int n;
        write_mode(MODE_ENC);
        sink_hold_req = 1'b1;
        for (n = 0; n < 6; n++) begin
            send_word(DATA_W'($urandom_range(0, 255)), n == 5);
        end
        wait_results_done();
    endtask

    task automatic test_random_blocks(input logic mode_bit, input bit with_idle);
        int                n;
        int                block_left;
        int                pick;
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] prev;
        write_mode(mode_bit);
        idle_en    = with_idle;
        block_left = $urandom_range(1, 64);
        prev       = '0;
        for (n = 0; n < PHASE_WORDS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                value = DATA_W'($urandom_range(0, 255));
            end else if (pick < 75) begin
                value = DATA_W'($urandom_range(0, 7));
            end else if (pick < 85) begin
                value = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
            end else begin
                value = prev;
            end
            prev = value;
            block_left--;
            send_word(value, block_left == 0 || $urandom_range(0, 199) == 0);
            if (block_left <= 0) begin
                block_left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 64);
            end
        end
        wait_results_done();
    endtask

    initial begin : sink_ready
        @(posedge i_clk);
        forever begin
            if (sink_hold_req) begin
                i_m_axis_tready <= 1'b0;
                repeat (SINK_HOLD_LEN) @(posedge i_clk);
                sink_hold_req = 1'b0;
            end else if (idle_en && $urandom_range(0, 4) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (code_expect_q.size() == 0) begin
                report_error($sformatf("unexpected word code=%0d", o_m_axis_tdata));
            end else begin
                if (o_m_axis_tdata !== code_expect_q[0]) begin
                    report_error($sformatf("code got %0d expected %0d",
                                           o_m_axis_tdata, code_expect_q[0]));
                end
                void'(code_expect_q.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
            || (o_m_axis_tvalid && i_m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: timeout with %0d words outstanding", code_expect_q.size());
            $display("tb: done, errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int ph;
        restore_identity();
        codec_mode = MODE_ENC;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_encode();
        test_directed_decode();
        test_output_backpressure();
        for (ph = 0; ph < 6; ph++) begin
            test_random_blocks((ph % 2 == 1) ? MODE_DEC : MODE_ENC, ph < 5);
        end

        repeat (SYMBOLS + 8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/mtf_pkg.sv
sv/mtf_cell.sv
sv/move_to_front_codec_unit.sv
tb/tb.sv
